### sv/bvts_pkg.sv
// Shared constants, codes and types of the bricked volume trilinear sampler.
// Used by every module of the block but bvts_ram; depends on nothing.
`default_nettype none

package bvts_pkg;

  localparam int BRICK_SIDE     = 8;
  localparam int BRICK_BITS     = $clog2(BRICK_SIDE);
  localparam int MAX_BRICKS     = 256;
  localparam int SLOT_BITS      = $clog2(MAX_BRICKS);
  localparam int LOOKUP_ENTRIES = 4096;
  localparam int LU_BITS        = $clog2(LOOKUP_ENTRIES);
  localparam int BANKS          = 8;
  localparam int LOCAL_BITS     = 3 * (BRICK_BITS - 1);
  localparam int BANK_DEPTH     = MAX_BRICKS * (1 << LOCAL_BITS);
  localparam int BANK_AW        = SLOT_BITS + LOCAL_BITS;
  localparam int NB_W           = 9 - BRICK_BITS;
  localparam int NBXY_W         = 2 * NB_W;
  localparam int LI_W           = 16;
  localparam int CQ_DEPTH       = 4;
  localparam int CQ_AW          = $clog2(CQ_DEPTH);
  localparam int OQ_DEPTH       = 16;
  localparam int OQ_AW          = $clog2(OQ_DEPTH);
  localparam int DENSITY_FULL   = 65535;
  localparam logic [16:0] POS_ONE = 17'h10000;
  localparam logic [7:0] DIM_RESET = 8'd128;

  localparam logic [1:0] CFG_DIM_X = 2'd0;
  localparam logic [1:0] CFG_DIM_Y = 2'd1;
  localparam logic [1:0] CFG_DIM_Z = 2'd2;

  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_MAXIMUM = 2'd1,
    OP_DENSITY = 2'd2,
    OP_SAMPLE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [7:0] dim_x;
    logic [7:0] dim_y;
    logic [7:0] dim_z;
  } cfg_t;

  typedef struct packed {
    logic [15:0] fx;
    logic [15:0] fy;
    logic [15:0] fz;
  } frac_t;

  typedef struct packed {
    op_t                op;
    logic               beyond;
    logic [16:0]        addr;
    logic [31:0]        data;
    logic signed [9:0]  base_x;
    logic signed [9:0]  base_y;
    logic signed [9:0]  base_z;
    frac_t              frac;
  } cmd_t;

  typedef struct packed {
    logic room;
    logic full;
  } oq_status_t;

endpackage

`default_nettype wire

### sv/bricked_volume_trilinear_sampler.sv
// Top level of the bricked volume trilinear sampler: configuration registers,
// front end, back end and result queue. Depends on bvts_pkg and all bvts_ modules.
//
//   channel  direction  handshake              payload
//   in_      request    in_valid / in_stall    operation, pos_x/y/z, load_address, load_data
//   out_     result     out_valid / out_stall  density
//   cfg_     write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request is taken per cycle while in_stall is low; a sample's density goes through
// the command queue, the eight-bank fetch and three blend levels to the result queue.
// After reset a pass clears all 4096 brick lookup entries; requests wait until it ends.
// Sixteen result credits let requests flow while out_stall holds; when they run out,
// further sample requests wait in a four-deep command queue, then in_stall rises.
`default_nettype none

module bricked_volume_trilinear_sampler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [16:0] in_pos_x,
  input  logic [16:0] in_pos_y,
  input  logic [16:0] in_pos_z,
  input  logic [16:0] in_load_address,
  input  logic [31:0] in_load_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_density,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  bvts_pkg::cfg_t        cfg_r;
  logic                  q_valid;
  bvts_pkg::cmd_t        q_head;
  logic                  pop;
  logic                  take;
  logic                  clearing;
  logic                  res_valid;
  logic [31:0]           res_density;
  bvts_pkg::oq_status_t  oq_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dim_x <= bvts_pkg::DIM_RESET;
      cfg_r.dim_y <= bvts_pkg::DIM_RESET;
      cfg_r.dim_z <= bvts_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bvts_pkg::CFG_DIM_X: cfg_r.dim_x <= cfg_data;
        bvts_pkg::CFG_DIM_Y: cfg_r.dim_y <= cfg_data;
        bvts_pkg::CFG_DIM_Z: cfg_r.dim_z <= cfg_data;
        default: ;
      endcase
    end
  end

  bvts_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .hold            (clearing),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_load_address (in_load_address),
    .in_load_data    (in_load_data),
    .pop             (pop),
    .q_valid         (q_valid),
    .q_head          (q_head)
  );

  bvts_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .pop         (pop),
    .take        (take),
    .oq_status   (oq_status),
    .clearing    (clearing),
    .res_valid   (res_valid),
    .res_density (res_density)
  );

  bvts_outq u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .push        (res_valid),
    .push_data   (res_density),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_density (out_density),
    .status      (oq_status)
  );

`ifndef SYNTHESIS
  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !res_valid)
    else $error("Result produced during the lookup clearing pass.");

  a_result_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !oq_status.full)
    else $error("Result arrived while the result queue was full.");

  a_clear_runs_once: assert property (@(posedge clk) disable iff (!rst_n)
    !clearing |=> !clearing)
    else $error("Lookup clearing pass restarted without a reset.");
`endif

endmodule

`default_nettype wire

### sv/bvts_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing; the lookup, maxima and density stores of the sampler are built from it.
`default_nettype none

module bvts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/bvts_front.sv
// Front end: accepts requests, maps sample positions to voxel space and
// queues decoded commands for the back end. Depends on bvts_pkg.
`default_nettype none

module bvts_front (
  input  logic            clk,
  input  logic            rst_n,
  input  bvts_pkg::cfg_t  cfg,
  input  logic            hold,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_operation,
  input  logic [16:0]     in_pos_x,
  input  logic [16:0]     in_pos_y,
  input  logic [16:0]     in_pos_z,
  input  logic [16:0]     in_load_address,
  input  logic [31:0]     in_load_data,
  input  logic            pop,
  output logic            q_valid,
  output bvts_pkg::cmd_t  q_head
);

  bvts_pkg::cmd_t                 cq_r [bvts_pkg::CQ_DEPTH];
  logic [bvts_pkg::CQ_AW-1:0]     wr_r, wr_nxt, rd_r, rd_nxt;
  logic [bvts_pkg::CQ_AW:0]       cnt_r, cnt_nxt;
  logic                           push;
  bvts_pkg::cmd_t                 cmd;
  logic [24:0]                    tx, ty, tz;

  assign tx = 25'(in_pos_x) * 25'(cfg.dim_x) + 25'd32768;
  assign ty = 25'(in_pos_y) * 25'(cfg.dim_y) + 25'd32768;
  assign tz = 25'(in_pos_z) * 25'(cfg.dim_z) + 25'd32768;

  always_comb begin
    cmd.op      = bvts_pkg::op_t'(in_operation);
    cmd.beyond  = (in_pos_x > bvts_pkg::POS_ONE) || (in_pos_y > bvts_pkg::POS_ONE) ||
                  (in_pos_z > bvts_pkg::POS_ONE);
    cmd.addr    = in_load_address;
    cmd.data    = in_load_data;
    cmd.base_x  = $signed({1'b0, tx[24:16]}) - 10'sd1;
    cmd.base_y  = $signed({1'b0, ty[24:16]}) - 10'sd1;
    cmd.base_z  = $signed({1'b0, tz[24:16]}) - 10'sd1;
    cmd.frac.fx = tx[15:0];
    cmd.frac.fy = ty[15:0];
    cmd.frac.fz = tz[15:0];
  end

  assign in_stall = (cnt_r == (bvts_pkg::CQ_AW + 1)'(bvts_pkg::CQ_DEPTH)) || hold;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_head   = cq_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (bvts_pkg::CQ_AW + 1)'(push) - (bvts_pkg::CQ_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cq_r[wr_r] <= cmd;
    end
  end

endmodule

`default_nettype wire

### sv/bvts_back.sv
// Back end: clears the brick lookup after reset, performs loads and runs the
// eight-corner fetch and trilinear blend pipeline. Depends on bvts_pkg, bvts_ram.
`default_nettype none

module bvts_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bvts_pkg::cfg_t        cfg,
  input  logic                  q_valid,
  input  bvts_pkg::cmd_t        q_head,
  output logic                  pop,
  output logic                  take,
  input  bvts_pkg::oq_status_t  oq_status,
  output logic                  clearing,
  output logic                  res_valid,
  output logic [31:0]           res_density
);

  localparam int BB = bvts_pkg::BRICK_BITS;
  localparam int NB = bvts_pkg::BANKS;
  localparam logic [bvts_pkg::SLOT_BITS:0] EMPTY = {1'b1, {bvts_pkg::SLOT_BITS{1'b0}}};

  function automatic logic [bvts_pkg::NB_W-1:0] bricks_along(input logic [7:0] dim);
    logic [8:0] s;
    s = {1'b0, dim} + 9'(bvts_pkg::BRICK_SIDE - 1);
    return s[8:BB];
  endfunction

  function automatic logic inside_dim(input logic signed [9:0] c, input logic [7:0] dim);
    return !c[9] && (c[8:0] < {1'b0, dim});
  endfunction

  function automatic logic [31:0] scale_code(input logic [47:0] prod);
    logic [47:0] n;
    logic [31:0] a;
    logic [15:0] lo, hi, mid;
    logic [17:0] r;
    logic [32:0] q;
    n   = prod + 48'd32767;
    a   = n[47:16];
    lo  = n[15:0];
    hi  = a[31:16];
    mid = a[15:0];
    r   = 18'(hi) + 18'(mid) + 18'(lo);
    q   = 33'(a) + 33'(hi);
    if (r >= 18'(3 * bvts_pkg::DENSITY_FULL)) begin
      q = q + 33'd3;
    end else if (r >= 18'(2 * bvts_pkg::DENSITY_FULL)) begin
      q = q + 33'd2;
    end else if (r >= 18'(bvts_pkg::DENSITY_FULL)) begin
      q = q + 33'd1;
    end
    return q[31:0];
  endfunction

  function automatic logic signed [49:0] blend_mul(input logic [31:0] a, input logic [31:0] b,
                                                  input logic [15:0] f);
    logic signed [32:0] d;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    return d * $signed({1'b0, f});
  endfunction

  function automatic logic [31:0] blend_fin(input logic [31:0] a, input logic signed [49:0] p);
    logic signed [49:0] s;
    s = (p + 50'sd32768) >>> 16;
    s = s + $signed({18'b0, a});
    return s[31:0];
  endfunction

  logic [bvts_pkg::LU_BITS-1:0]  clr_cnt_r;
  logic                          clearing_r;
  logic [bvts_pkg::NB_W-1:0]     nbx_r;
  logic [bvts_pkg::NBXY_W-1:0]   nbxy_r;

  logic signed [9:0]             cx [NB];
  logic signed [9:0]             cy [NB];
  logic signed [9:0]             cz [NB];
  logic [bvts_pkg::LI_W-1:0]     li [NB];
  logic [NB-1:0]                 ok0;
  logic [bvts_pkg::LOCAL_BITS-1:0] loc0 [NB];
  logic [bvts_pkg::LU_BITS-1:0]  lu_raddr [NB];
  logic [bvts_pkg::SLOT_BITS:0]  lu_rdata [NB];
  logic                          lu_we;
  logic [bvts_pkg::LU_BITS-1:0]  lu_waddr;
  logic [bvts_pkg::SLOT_BITS:0]  lu_wdata;

  logic [bvts_pkg::SLOT_BITS-1:0] slot1 [NB];
  logic [NB-1:0]                 ok1;
  logic [bvts_pkg::BANK_AW-1:0]  dn_raddr [NB];
  logic [31:0]                   mx_rdata [NB];
  logic [15:0]                   dn_rdata [NB];
  logic                          mx_we;
  logic [NB-1:0]                 dn_we;
  logic [2:0]                    dn_bank;
  logic [bvts_pkg::BANK_AW-1:0]  dn_waddr;

  logic [31:0]                   v0 [NB];
  logic [31:0]                   v1 [NB];
  logic [31:0]                   v2 [NB];
  logic [31:0]                   v3 [NB];

  logic                          s1_vld_r;
  bvts_pkg::cmd_t                s1_cmd_r;
  logic [NB-1:0]                 s1_ok_r;
  logic [bvts_pkg::LOCAL_BITS-1:0] s1_loc_r [NB];

  logic                          s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r;
  logic                          s7_vld_r, s8_vld_r, s9_vld_r, res_vld_r;
  bvts_pkg::frac_t               s2_frac_r, s3_frac_r, s4_frac_r, s5_frac_r;
  bvts_pkg::frac_t               s6_frac_r, s7_frac_r, s8_frac_r;
  logic [2:0]                    s2_par_r, s3_par_r;
  logic [NB-1:0]                 s2_ok_r, s3_ok_r;
  logic [47:0]                   s3_prod_r [NB];
  logic [31:0]                   s4_corner_r [NB];
  logic [31:0]                   s5_xa_r [4];
  logic signed [49:0]            s5_xp_r [4];
  logic [31:0]                   s6_x_r [4];
  logic [31:0]                   s7_ya_r [2];
  logic signed [49:0]            s7_yp_r [2];
  logic [31:0]                   s8_y_r [2];
  logic [31:0]                   s9_za_r;
  logic signed [49:0]            s9_zp_r;
  logic [31:0]                   res_r;

  assign clearing    = clearing_r;
  assign pop         = q_valid && !clearing_r &&
                       ((q_head.op != bvts_pkg::OP_SAMPLE) || oq_status.room);
  assign take        = pop && (q_head.op == bvts_pkg::OP_SAMPLE);
  assign res_valid   = res_vld_r;
  assign res_density = res_r;

  // Stage 0: per bank, pick the corner whose coordinate parity matches the bank.
  always_comb begin
    for (int b = 0; b < NB; b++) begin
      cx[b] = (q_head.base_x[0] == b[0]) ? q_head.base_x : q_head.base_x + 10'sd1;
      cy[b] = (q_head.base_y[0] == b[1]) ? q_head.base_y : q_head.base_y + 10'sd1;
      cz[b] = (q_head.base_z[0] == b[2]) ? q_head.base_z : q_head.base_z + 10'sd1;
      li[b] = bvts_pkg::LI_W'(cz[b][8:BB]) * bvts_pkg::LI_W'(nbxy_r) +
              bvts_pkg::LI_W'(cy[b][8:BB]) * bvts_pkg::LI_W'(nbx_r) +
              bvts_pkg::LI_W'(cx[b][8:BB]);
      ok0[b] = !q_head.beyond && inside_dim(cx[b], cfg.dim_x) &&
               inside_dim(cy[b], cfg.dim_y) && inside_dim(cz[b], cfg.dim_z) &&
               (li[b] < bvts_pkg::LI_W'(bvts_pkg::LOOKUP_ENTRIES));
      loc0[b] = {cz[b][BB-1:1], cy[b][BB-1:1], cx[b][BB-1:1]};
      lu_raddr[b] = li[b][bvts_pkg::LU_BITS-1:0];
    end
  end

  always_comb begin
    lu_we    = clearing_r || (pop && (q_head.op == bvts_pkg::OP_LOOKUP) &&
               (q_head.addr < 17'(bvts_pkg::LOOKUP_ENTRIES)));
    lu_waddr = clearing_r ? clr_cnt_r : q_head.addr[bvts_pkg::LU_BITS-1:0];
    if (clearing_r || (q_head.data >= 32'(bvts_pkg::MAX_BRICKS))) begin
      lu_wdata = EMPTY;
    end else begin
      lu_wdata = {1'b0, q_head.data[bvts_pkg::SLOT_BITS-1:0]};
    end
  end

  // Stage 1: slot known; fetch maxima and density codes, perform those loads.
  always_comb begin
    for (int b = 0; b < NB; b++) begin
      slot1[b]    = lu_rdata[b][bvts_pkg::SLOT_BITS-1:0];
      ok1[b]      = s1_ok_r[b] && !lu_rdata[b][bvts_pkg::SLOT_BITS];
      dn_raddr[b] = {slot1[b], s1_loc_r[b]};
    end
  end

  always_comb begin
    mx_we    = s1_vld_r && (s1_cmd_r.op == bvts_pkg::OP_MAXIMUM) &&
               (s1_cmd_r.addr < 17'(bvts_pkg::MAX_BRICKS));
    dn_bank  = {s1_cmd_r.addr[2*BB], s1_cmd_r.addr[BB], s1_cmd_r.addr[0]};
    dn_waddr = {s1_cmd_r.addr[3*BB +: bvts_pkg::SLOT_BITS], s1_cmd_r.addr[3*BB-1:2*BB+1],
                s1_cmd_r.addr[2*BB-1:BB+1], s1_cmd_r.addr[BB-1:1]};
    for (int b = 0; b < NB; b++) begin
      dn_we[b] = s1_vld_r && (s1_cmd_r.op == bvts_pkg::OP_DENSITY) && (dn_bank == 3'(b));
    end
  end

  for (genvar g = 0; g < NB; g++) begin : g_bank
    bvts_ram #(.WIDTH(bvts_pkg::SLOT_BITS + 1), .DEPTH(bvts_pkg::LOOKUP_ENTRIES)) u_lookup (
      .clk   (clk),
      .we    (lu_we),
      .waddr (lu_waddr),
      .wdata (lu_wdata),
      .raddr (lu_raddr[g]),
      .rdata (lu_rdata[g])
    );
    bvts_ram #(.WIDTH(32), .DEPTH(bvts_pkg::MAX_BRICKS)) u_maxima (
      .clk   (clk),
      .we    (mx_we),
      .waddr (s1_cmd_r.addr[bvts_pkg::SLOT_BITS-1:0]),
      .wdata (s1_cmd_r.data),
      .raddr (slot1[g]),
      .rdata (mx_rdata[g])
    );
    bvts_ram #(.WIDTH(16), .DEPTH(bvts_pkg::BANK_DEPTH)) u_density (
      .clk   (clk),
      .we    (dn_we[g]),
      .waddr (dn_waddr),
      .wdata (s1_cmd_r.data[15:0]),
      .raddr (dn_raddr[g]),
      .rdata (dn_rdata[g])
    );
  end

  // Stage 3: scale codes and reorder from banks to corners {dz, dy, dx}.
  always_comb begin
    for (int b = 0; b < NB; b++) begin
      v0[b] = s3_ok_r[b] ? scale_code(s3_prod_r[b]) : 32'd0;
    end
    for (int b = 0; b < NB; b++) begin
      v1[b] = s3_par_r[0] ? v0[b ^ 1] : v0[b];
    end
    for (int b = 0; b < NB; b++) begin
      v2[b] = s3_par_r[1] ? v1[b ^ 2] : v1[b];
    end
    for (int b = 0; b < NB; b++) begin
      v3[b] = s3_par_r[2] ? v2[b ^ 4] : v2[b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clearing_r <= 1'b1;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      s3_vld_r   <= 1'b0;
      s4_vld_r   <= 1'b0;
      s5_vld_r   <= 1'b0;
      s6_vld_r   <= 1'b0;
      s7_vld_r   <= 1'b0;
      s8_vld_r   <= 1'b0;
      s9_vld_r   <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          clearing_r <= 1'b0;
        end
      end
      s1_vld_r  <= pop;
      s2_vld_r  <= s1_vld_r && (s1_cmd_r.op == bvts_pkg::OP_SAMPLE);
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      s5_vld_r  <= s4_vld_r;
      s6_vld_r  <= s5_vld_r;
      s7_vld_r  <= s6_vld_r;
      s8_vld_r  <= s7_vld_r;
      s9_vld_r  <= s8_vld_r;
      res_vld_r <= s9_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    nbx_r  <= bricks_along(cfg.dim_x);
    nbxy_r <= bvts_pkg::NBXY_W'(bricks_along(cfg.dim_x)) *
              bvts_pkg::NBXY_W'(bricks_along(cfg.dim_y));

    s1_cmd_r <= q_head;
    s1_ok_r  <= ok0;
    for (int b = 0; b < NB; b++) begin
      s1_loc_r[b] <= loc0[b];
    end

    s2_frac_r <= s1_cmd_r.frac;
    s2_par_r  <= {s1_cmd_r.base_z[0], s1_cmd_r.base_y[0], s1_cmd_r.base_x[0]};
    s2_ok_r   <= ok1;

    s3_frac_r <= s2_frac_r;
    s3_par_r  <= s2_par_r;
    s3_ok_r   <= s2_ok_r;
    for (int b = 0; b < NB; b++) begin
      s3_prod_r[b] <= 48'(mx_rdata[b]) * 48'(dn_rdata[b]);
    end

    s4_frac_r <= s3_frac_r;
    for (int b = 0; b < NB; b++) begin
      s4_corner_r[b] <= v3[b];
    end

    s5_frac_r <= s4_frac_r;
    for (int j = 0; j < 4; j++) begin
      s5_xa_r[j] <= s4_corner_r[2*j];
      s5_xp_r[j] <= blend_mul(s4_corner_r[2*j], s4_corner_r[2*j+1], s4_frac_r.fx);
    end

    s6_frac_r <= s5_frac_r;
    for (int j = 0; j < 4; j++) begin
      s6_x_r[j] <= blend_fin(s5_xa_r[j], s5_xp_r[j]);
    end

    s7_frac_r <= s6_frac_r;
    for (int k = 0; k < 2; k++) begin
      s7_ya_r[k] <= s6_x_r[2*k];
      s7_yp_r[k] <= blend_mul(s6_x_r[2*k], s6_x_r[2*k+1], s6_frac_r.fy);
    end

    s8_frac_r <= s7_frac_r;
    for (int k = 0; k < 2; k++) begin
      s8_y_r[k] <= blend_fin(s7_ya_r[k], s7_yp_r[k]);
    end

    s9_za_r <= s8_y_r[0];
    s9_zp_r <= blend_mul(s8_y_r[0], s8_y_r[1], s8_frac_r.fz);

    res_r <= blend_fin(s9_za_r, s9_zp_r);
  end

endmodule

`default_nettype wire

### sv/bvts_outq.sv
// Result queue with credit accounting for samples still in the pipeline or in the queue.
// Depends on bvts_pkg.
`default_nettype none

module bvts_outq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic                  push,
  input  logic [31:0]           push_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_density,
  output bvts_pkg::oq_status_t  status
);

  logic [31:0]                mem_r [bvts_pkg::OQ_DEPTH];
  logic [bvts_pkg::OQ_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [bvts_pkg::OQ_AW:0]   cnt_r, cnt_nxt, used_r, used_nxt;
  logic                       pop;

  assign out_valid   = (cnt_r != '0);
  assign out_density = mem_r[rd_r];
  assign pop         = out_valid && !out_stall;
  assign status.room = (used_r < (bvts_pkg::OQ_AW + 1)'(bvts_pkg::OQ_DEPTH));
  assign status.full = (cnt_r == (bvts_pkg::OQ_AW + 1)'(bvts_pkg::OQ_DEPTH));

  always_comb begin
    wr_nxt   = push ? wr_r + 1'b1 : wr_r;
    rd_nxt   = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt  = cnt_r + (bvts_pkg::OQ_AW + 1)'(push) - (bvts_pkg::OQ_AW + 1)'(pop);
    used_nxt = used_r + (bvts_pkg::OQ_AW + 1)'(take) - (bvts_pkg::OQ_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      cnt_r  <= '0;
      used_r <= '0;
    end else begin
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
      cnt_r  <= cnt_nxt;
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire
